/* rtl/core/double_delta_pdf_params_core_defines.svh */
// Assertion macros used by the core checker file
`ifndef DOUBLE_DELTA_PDF_PARAMS_CORE_DEFINES_SVH
`define DOUBLE_DELTA_PDF_PARAMS_CORE_DEFINES_SVH

`define DDP_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");

`define DDP_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");

`endif

/* rtl/core/ddp_pkg.sv */
`default_nettype none
package ddp_pkg;
   localparam int FracBits = 16;
   localparam int InW      = FracBits + 1;
   localparam int ProdW    = 2 * FracBits + 2;
   localparam int SqW      = FracBits;
   // cells: 1 product, 1 prep, SqW sqrt cells, 1 setup, FracBits divide cells, 1 final
   localparam int SqrtCells = SqW;
   localparam int DivCells  = FracBits;
   localparam int Latency   = SqrtCells + DivCells + 4;

   // floor(y/100) for y < 2^YW as (y*Recip100) >> RcpShift
   localparam int YW       = 2 * FracBits - 1;
   localparam int RcpShift = YW + 7;
   localparam logic [YW:0] Recip100 =
      (YW+1)'(((64'd1 << RcpShift) + 64'd99) / 64'd100);

   localparam logic [2:0] StOk       = 3'd0;
   localparam logic [2:0] StMeanZero = 3'd1;
   localparam logic [2:0] StVarZero  = 3'd2;
   localparam logic [2:0] StVarLarge = 3'd3;
   localparam logic [2:0] StClipped  = 3'd4;

   localparam logic [1:0] RegNone  = 2'd0;
   localparam logic [1:0] RegInner = 2'd1;
   localparam logic [1:0] RegLow   = 2'd2;
   localparam logic [1:0] RegHigh  = 2'd3;

   typedef struct packed {
      logic             valid;
      logic [InW-1:0]   m;
      logic [InW-1:0]   om;
      logic [InW-1:0]   g;
      logic [2:0]       st;
      logic             err;
      logic [2*InW-1:0] rem;   // sqrt radicand remainder
      logic [2*InW-1:0] root;  // scaled partial root, wide until the last digit
   } sq_cell_type;

   typedef struct packed {
      logic             valid;
      logic [InW-1:0]   m;
      logic [InW-1:0]   om;
      logic [InW-1:0]   s;
      logic [1:0]       rgn;
      logic [2:0]       st;
      logic [ProdW:0]   rem;
      logic [ProdW:0]   den;
      logic [FracBits:0] q;
   } dv_cell_type;
endpackage
`default_nettype wire

/* rtl/core/ddp_sqrt_cell.sv */
`default_nettype none
// one restoring square-root digit: bit weight (4^k) fixed per cell
module ddp_sqrt_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [4:0]             digit,
   input  wire ddp_pkg::sq_cell_type   cell_in,
   output ddp_pkg::sq_cell_type        cell_out
);
   ddp_pkg::sq_cell_type cell_ff, cell_in_w;
   logic [2*ddp_pkg::InW-1:0] bitw, trial;

   always_comb begin
      bitw = '0;
      bitw[{digit, 1'b0}] = 1'b1;
      trial = cell_in.root + bitw;
      cell_in_w = cell_in;
      if (cell_in.rem >= trial) begin
         cell_in_w.rem  = cell_in.rem - trial;
         cell_in_w.root = (cell_in.root >> 1) + bitw;
      end else begin
         cell_in_w.root = cell_in.root >> 1;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_w;
      if (reset) cell_ff.valid <= 1'b0;
   end
   assign cell_out = cell_ff;
endmodule
`default_nettype wire

/* rtl/core/ddp_div_cell.sv */
`default_nettype none
// one restoring quotient bit per cell
module ddp_div_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire ddp_pkg::dv_cell_type   cell_in,
   output ddp_pkg::dv_cell_type        cell_out
);
   ddp_pkg::dv_cell_type cell_ff, cell_in_w;
   logic [ddp_pkg::ProdW+1:0] sh;

   always_comb begin
      cell_in_w = cell_in;
      sh = {cell_in.rem, 1'b0};
      cell_in_w.q = {cell_in.q[ddp_pkg::FracBits-1:0], 1'b0};
      if (sh >= {1'b0, cell_in.den}) begin
         sh = sh - {1'b0, cell_in.den};
         cell_in_w.q[0] = 1'b1;
      end
      cell_in_w.rem = sh[ddp_pkg::ProdW:0];
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in_w;
      if (reset) cell_ff.valid <= 1'b0;
   end
   assign cell_out = cell_ff;
endmodule
`default_nettype wire

/* rtl/core/double_delta_pdf_params_core.sv */
`default_nettype none
// Throughput: one item per cycle; busy is never raised.
// The pipeline holds a product stage, a chain of 16 square-root digit cells and 16 quotient-bit cells.
// Synchronous active-high reset clears every cell's valid bit; no result follows.
// The receiver cannot stall: each result stands for exactly one cycle.
module double_delta_pdf_params_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [ddp_pkg::InW-1:0] req_mean,
   input  wire logic [ddp_pkg::InW-1:0] req_variance,
   output logic                         rsp_valid,
   output logic [ddp_pkg::InW-1:0]      rsp_pos_low,
   output logic [ddp_pkg::InW-1:0]      rsp_pos_high,
   output logic [ddp_pkg::InW-1:0]      rsp_weight_low,
   output logic [ddp_pkg::InW-1:0]      rsp_weight_high,
   output logic [1:0]                   rsp_region,
   output logic [2:0]                   rsp_status
);
   localparam int F = ddp_pkg::FracBits;
   localparam int W = ddp_pkg::InW;
   localparam int P = ddp_pkg::ProdW;
   localparam int Y = ddp_pkg::YW;
   localparam logic [W-1:0] One  = W'(1) << F;
   localparam logic [W-1:0] Half = W'(1) << (F - 1);

   assign busy = 1'b0;

   // product stage: m*(1-m)
   logic [W-1:0]   om_w;
   logic [2*W-1:0] p_w;
   logic           s0_vld_ff;
   logic [W-1:0]   s0_m_ff, s0_v_ff, s0_om_ff;
   logic [Y-1:0]   s0_p_ff;
   always_comb begin
      om_w = (req_mean < One) ? One - req_mean : '0;
      p_w  = req_mean * om_w;
   end
   always_ff @(posedge clock) begin
      if (reset) s0_vld_ff <= 1'b0;
      else s0_vld_ff <= start;
      s0_m_ff  <= req_mean;
      s0_v_ff  <= req_variance;
      s0_om_ff <= om_w;
      // m*(1-m) peaks at ONE*ONE/4
      s0_p_ff  <= p_w[Y-1:0];
   end

   // prep stage: gmax, checks
   logic [W-1:0]   gmax_w;
   logic [Y-1:0]   pc_w, p99_w;
   logic [2*Y:0]   prod_w;
   ddp_pkg::sq_cell_type prep_in, prep_ff;
   always_comb begin
      // floor(99p/100) = p - ceil(p/100)
      pc_w   = s0_p_ff + Y'(99);
      prod_w = {{(Y+1){1'b0}}, pc_w} * {{Y{1'b0}}, ddp_pkg::Recip100};
      p99_w  = s0_p_ff - Y'(prod_w[2*Y:ddp_pkg::RcpShift]);
      gmax_w = W'(p99_w >> F);
      prep_in = '0;
      prep_in.valid = s0_vld_ff;
      prep_in.m  = s0_m_ff;
      prep_in.om = s0_om_ff;
      prep_in.st = ddp_pkg::StOk;
      prep_in.g  = s0_v_ff;
      if (s0_m_ff == '0) begin
         prep_in.st = ddp_pkg::StMeanZero; prep_in.err = 1'b1;
      end else if (s0_v_ff == '0) begin
         prep_in.st = ddp_pkg::StVarZero; prep_in.err = 1'b1;
      end else if (({2'b0, s0_v_ff} << 2) > (W+2)'(gmax_w) * (W+2)'(5)) begin
         prep_in.st = ddp_pkg::StVarLarge; prep_in.err = 1'b1;
      end else if (s0_v_ff > gmax_w) begin
         prep_in.st = ddp_pkg::StClipped; prep_in.g = gmax_w;
      end
      prep_in.rem  = (2*W)'(prep_in.g) << F;
      prep_in.root = '0;
   end
   always_ff @(posedge clock) begin
      prep_ff <= prep_in;
      if (reset) prep_ff.valid <= 1'b0;
   end

   // sqrt chain
   ddp_pkg::sq_cell_type sq [ddp_pkg::SqrtCells+1];
   assign sq[0] = prep_ff;
   for (genvar k = 0; k < ddp_pkg::SqrtCells; k++) begin : g_sq
      ddp_sqrt_cell u_cell (
         .clock(clock), .reset(reset),
         .digit(5'(ddp_pkg::SqrtCells - 1 - k)),
         .cell_in(sq[k]), .cell_out(sq[k+1])
      );
   end

   // setup: region, denominator
   ddp_pkg::sq_cell_type sqo;
   ddp_pkg::dv_cell_type set_in, set_ff;
   logic [W-1:0] s_w, base_w;
   logic [P:0]   gsh_w;
   always_comb begin
      sqo = sq[ddp_pkg::SqrtCells];
      s_w = W'(sqo.root);
      gsh_w = (P+1)'(sqo.g) << F;
      set_in = '0;
      set_in.valid = sqo.valid;
      set_in.m  = sqo.m;
      set_in.om = sqo.om;
      set_in.s  = s_w;
      set_in.st = sqo.st;
      if (sqo.err) set_in.rgn = ddp_pkg::RegNone;
      else if ((sqo.m <= Half && s_w <= sqo.m) || (sqo.m >= Half && s_w <= sqo.om))
         set_in.rgn = ddp_pkg::RegInner;
      else if (sqo.m <= Half) set_in.rgn = ddp_pkg::RegLow;
      else set_in.rgn = ddp_pkg::RegHigh;
      base_w = (set_in.rgn == ddp_pkg::RegLow) ? sqo.m : sqo.om;
      set_in.rem = gsh_w;
      set_in.den = (P+1)'(base_w * base_w) + gsh_w;
      set_in.q   = '0;
   end
   always_ff @(posedge clock) begin
      set_ff <= set_in;
      if (reset) set_ff.valid <= 1'b0;
   end

   // divide chain
   ddp_pkg::dv_cell_type dv [ddp_pkg::DivCells+1];
   assign dv[0] = set_ff;
   for (genvar k = 0; k < ddp_pkg::DivCells; k++) begin : g_dv
      ddp_div_cell u_cell (
         .clock(clock), .reset(reset), .cell_in(dv[k]), .cell_out(dv[k+1])
      );
   end

   // output register
   ddp_pkg::dv_cell_type dvo;
   logic [W-1:0] wq_w, plo_in, phi_in, wlo_in, whi_in;
   logic [W:0]   sum_w;
   logic         vld_ff;
   logic [W-1:0] plo_ff, phi_ff, wlo_ff, whi_ff;
   logic [1:0]   rgn_ff;
   logic [2:0]   st_ff;
   always_comb begin
      dvo = dv[ddp_pkg::DivCells];
      wq_w = (dvo.den == '0) ? One : W'(dvo.q);
      sum_w = {1'b0, dvo.m} + {1'b0, dvo.s};
      plo_in = (dvo.m > dvo.s) ? dvo.m - dvo.s : '0;
      phi_in = (sum_w > (W+1)'(One)) ? One : sum_w[W-1:0];
      wlo_in = Half; whi_in = Half;
      case (dvo.rgn)
         ddp_pkg::RegInner: ;
         ddp_pkg::RegLow: begin
            plo_in = '0; wlo_in = wq_w; whi_in = One - wq_w;
         end
         ddp_pkg::RegHigh: begin
            phi_in = One; whi_in = wq_w; wlo_in = One - wq_w;
         end
         default: begin
            plo_in = '0; phi_in = '0; wlo_in = '0; whi_in = '0;
         end
      endcase
   end
   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else vld_ff <= dvo.valid;
      plo_ff <= plo_in; phi_ff <= phi_in; wlo_ff <= wlo_in; whi_ff <= whi_in;
      rgn_ff <= dvo.rgn; st_ff <= dvo.st;
   end

   assign rsp_valid       = vld_ff;
   assign rsp_pos_low     = plo_ff;
   assign rsp_pos_high    = phi_ff;
   assign rsp_weight_low  = wlo_ff;
   assign rsp_weight_high = whi_ff;
   assign rsp_region      = rgn_ff;
   assign rsp_status      = st_ff;
endmodule
`default_nettype wire

/* rtl/core/ddp_checker.sv */
`default_nettype none
`include "double_delta_pdf_params_core_defines.svh"
module ddp_checker (
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    busy,
   input wire logic                    rsp_valid,
   input wire logic [ddp_pkg::InW-1:0] rsp_pos_low,
   input wire logic [ddp_pkg::InW-1:0] rsp_weight_low,
   input wire logic [ddp_pkg::InW-1:0] rsp_weight_high,
   input wire logic [1:0]              rsp_region,
   input wire logic [2:0]              rsp_status
);
   localparam logic [ddp_pkg::InW:0] OneSum = (ddp_pkg::InW+1)'(1) << ddp_pkg::FracBits;

   // errors carry an empty result
   `DDP_ASSERT_IMP(a_err_zero, clock, reset,
      rsp_valid && rsp_status != ddp_pkg::StOk && rsp_status != ddp_pkg::StClipped,
      rsp_region == ddp_pkg::RegNone)
   // weights add to one when valid and not an error
   `DDP_ASSERT_IMP(a_wsum, clock, reset, rsp_valid && rsp_region != ddp_pkg::RegNone,
      {1'b0, rsp_weight_low} + {1'b0, rsp_weight_high} == OneSum)
   `DDP_ASSERT_IMP(a_low_zero, clock, reset, rsp_valid && rsp_region == ddp_pkg::RegLow,
      rsp_pos_low == '0)
   `DDP_ASSERT_NXT(a_nobusy, clock, reset, 1'b1, !busy)
endmodule

bind double_delta_pdf_params_core ddp_checker u_ddp_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid),
   .rsp_pos_low(rsp_pos_low), .rsp_weight_low(rsp_weight_low),
   .rsp_weight_high(rsp_weight_high), .rsp_region(rsp_region),
   .rsp_status(rsp_status)
);
`default_nettype wire

/* dv/ddp_checker.sv */
`default_nettype none
module ddp_scoreboard (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [16:0] req_mean,
   input  wire logic [16:0] req_variance,
   input  wire logic        rsp_valid,
   input  wire logic [16:0] rsp_pos_low,
   input  wire logic [16:0] rsp_pos_high,
   input  wire logic [16:0] rsp_weight_low,
   input  wire logic [16:0] rsp_weight_high,
   input  wire logic [1:0]  rsp_region,
   input  wire logic [2:0]  rsp_status,
   output int               fail_count,
   output int               pending,
   output int               beats_seen,
   output int               clip_seen,
   output int               rgn_seen [4]
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] One = 64'd1 << ddp_pkg::FracBits;

   typedef struct packed {
      logic [16:0] plo;
      logic [16:0] phi;
      logic [16:0] wlo;
      logic [16:0] whi;
      logic [1:0]  rgn;
      logic [2:0]  st;
   } pdf_params_type;

   pdf_params_type expected_q[$];

   function automatic logic [63:0] isqrt(logic [63:0] x);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [63:0] weight_frac(logic [63:0] num, logic [63:0] den);
      logic [63:0] r;
      logic [63:0] q;
      r = num;
      q = 0;
      if (den == 0 || num >= den) return One;
      for (int i = 0; i < ddp_pkg::FracBits; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r = r - den;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   function automatic pdf_params_type pdf_params(logic [16:0] mean_in, logic [16:0] var_in);
      logic [63:0] m, v, om, p, gmax, g, s, half;
      logic [63:0] plo, phi, wlo, whi;
      pdf_params_type r;
      m = 64'(mean_in);
      v = 64'(var_in);
      plo = 0; phi = 0; wlo = 0; whi = 0;
      r = '0;
      om = (m < One) ? One - m : 0;
      p = m * om;
      gmax = (p - (p + 99) / 100) >> ddp_pkg::FracBits;
      if (m == 0) begin
         r.st = ddp_pkg::StMeanZero;
      end else if (v == 0) begin
         r.st = ddp_pkg::StVarZero;
      end else if (4 * v > 5 * gmax) begin
         r.st = ddp_pkg::StVarLarge;
      end else begin
         r.st = ddp_pkg::StOk;
         g = v;
         if (v > gmax) begin
            g = gmax;
            r.st = ddp_pkg::StClipped;
         end
         s = isqrt(g << ddp_pkg::FracBits);
         half = One >> 1;
         if ((m <= half && s <= m) || (m >= half && s <= om)) begin
            r.rgn = ddp_pkg::RegInner;
            plo = (m > s) ? m - s : 0;
            phi = m + s;
            wlo = half;
            whi = half;
         end else if (m <= half) begin
            r.rgn = ddp_pkg::RegLow;
            phi = m + s;
            wlo = weight_frac(g << ddp_pkg::FracBits, m * m + (g << ddp_pkg::FracBits));
            whi = One - wlo;
         end else begin
            r.rgn = ddp_pkg::RegHigh;
            plo = (m > s) ? m - s : 0;
            phi = One;
            whi = weight_frac(g << ddp_pkg::FracBits, om * om + (g << ddp_pkg::FracBits));
            wlo = One - whi;
         end
         if (phi > One) phi = One;
      end
      r.plo = plo[16:0];
      r.phi = phi[16:0];
      r.wlo = wlo[16:0];
      r.whi = whi[16:0];
      return r;
   endfunction

   assign pending = expected_q.size();

   always @(posedge clock) begin
      pdf_params_type exp_r;
      pdf_params_type got;
      if (reset) begin
         fail_count <= 0;
         beats_seen <= 0;
         clip_seen  <= 0;
         for (int i = 0; i < 4; i++) rgn_seen[i] <= 0;
      end else begin
         if (start && !busy) expected_q.push_back(pdf_params(req_mean, req_variance));
         if (rsp_valid) begin
            got = '{rsp_pos_low, rsp_pos_high, rsp_weight_low, rsp_weight_high,
                    rsp_region, rsp_status};
            beats_seen <= beats_seen + 1;
            rgn_seen[rsp_region] <= rgn_seen[rsp_region] + 1;
            if (rsp_status == ddp_pkg::StClipped) clip_seen <= clip_seen + 1;
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("ERROR: unexpected result beat");
               fail_count <= fail_count + 1;
            end else begin
               exp_r = expected_q.pop_front();
               if (got !== exp_r) begin
                  if (fail_count < 10)
                     $display({"ERROR: exp plo=%0d phi=%0d wlo=%0d whi=%0d rgn=%0d st=%0d,",
                               " got plo=%0d phi=%0d wlo=%0d whi=%0d rgn=%0d st=%0d"},
                        exp_r.plo, exp_r.phi, exp_r.wlo, exp_r.whi, exp_r.rgn, exp_r.st,
                        got.plo, got.phi, got.wlo, got.whi, got.rgn, got.st);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

/* dv/tb_double_delta_pdf_params_core.sv */
`default_nettype none
module tb_double_delta_pdf_params_core;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic [16:0] req_mean = '0;
   logic [16:0] req_variance = '0;
   logic        busy, rsp_valid;
   logic [16:0] rsp_pos_low, rsp_pos_high, rsp_weight_low, rsp_weight_high;
   logic [1:0]  rsp_region;
   logic [2:0]  rsp_status;
   int          fail_count, pending, beats_seen, clip_seen;
   int          rgn_seen [4];

   always #2 clock = ~clock;

   double_delta_pdf_params_core u_dut (.*);

   ddp_scoreboard u_chk (.*);

   // drive one beat and hold it until accepted
   task automatic send_beat(logic [16:0] m, logic [16:0] v, bit gaps);
      int n;
      if (gaps && $urandom_range(0, 5) == 0) begin
         start <= 1'b0;
         n = $urandom_range(1, 18);
         repeat (n) @(posedge clock);
      end
      start        <= 1'b1;
      req_mean     <= m;
      req_variance <= v;
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [16:0] gmax_of(logic [16:0] m);
      longint om;
      longint p;
      om = (m < 17'h10000) ? 65536 - m : 0;
      p = longint'(m) * om;
      return 17'((p * 99 / 100) >> 16);
   endfunction

   initial begin
      logic [16:0] m, v, gm;
      int k;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: zero mean, zero variance, too large, mean at and above one,
      // variance above one, clip, each region, full-width bits
      send_beat(17'd0, 17'd100, 0);
      send_beat(17'd0, 17'd0, 0);
      send_beat(17'd30000, 17'd0, 0);
      send_beat(17'd32768, 17'd16000, 0);
      send_beat(17'd65536, 17'd1, 0);
      send_beat(17'd65536, 17'd0, 0);
      send_beat(17'h1FFFF, 17'h1FFFF, 0);
      send_beat(17'd32768, 17'h1FFFF, 0);
      send_beat(17'd32768, 17'd65536, 0);
      send_beat(17'd32768, 17'd16220, 0);
      send_beat(17'd32768, 17'd16300, 0);
      send_beat(17'd32768, 17'd100, 0);
      send_beat(17'd1000, 17'd5, 0);
      send_beat(17'd1000, 17'd900, 0);
      send_beat(17'd64000, 17'd900, 0);
      send_beat(17'd65535, 17'd1, 0);
      send_beat(17'd1, 17'd1, 0);
      send_beat(17'd32767, 17'd16000, 0);
      send_beat(17'd32769, 17'd16000, 0);
      send_beat(17'h15555, 17'h0AAAA, 0);
      for (int i = 0; i < 1900; i++) begin
         k = $urandom_range(0, 9);
         m = 17'($urandom_range(1, 65535));
         gm = gmax_of(m);
         case (k)
            0: begin m = 17'($urandom); v = 17'($urandom); end
            1: v = 17'($urandom_range(0, 65536));
            2: v = gm + 17'($urandom_range(0, gm / 4 + 1));
            default: v = 17'($urandom_range(1, gm > 0 ? gm : 1));
         endcase
         if (k == 3) m = $urandom_range(0, 1) ? 17'($urandom_range(1, 2000))
                                              : 17'($urandom_range(63536, 65535));
         send_beat(m, v, i < 1600);
      end
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (ddp_pkg::Latency + 10) @(posedge clock);
      $display("Ran %0d result beats: region1=%0d region2=%0d region3=%0d clipped=%0d",
               beats_seen, rgn_seen[1], rgn_seen[2], rgn_seen[3], clip_seen);
      if (fail_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2ms;
      $display("TEST FAILED");
      $finish;
   end
endmodule
`default_nettype wire
